/* hw/rtl/svpwm_pkg.sv */
`default_nettype none
// ============================================================================
// svpwm_pkg
// Shared types and constants for the space-vector compare generator.
// ============================================================================
package svpwm_pkg;

  // sqrt(3) in Q16
  localparam logic [17:0] SQRT3_Q16 = 18'd113512;
  localparam logic [15:0] PERIOD_RST = 16'd1000;

  // classified vector passed from front to back
  typedef struct packed {
    logic [2:0]  sector;
    logic [35:0] act_a;
    logic [35:0] act_b;
    logic [15:0] bus_voltage;
  } svpwm_cls_t;

endpackage
`default_nettype wire

/* hw/rtl/svpwm_front.sv */
`default_nettype none
// ============================================================================
// svpwm_front
// Sector detection and X/Y/Z active-term selection, two register stages.
// ============================================================================
module svpwm_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  wire signed [15:0]       u_alpha,
  input  wire signed [15:0]       u_beta,
  input  wire [15:0]              bus_voltage,
  input  wire                     adv,
  output logic                    out_valid,
  output svpwm_pkg::svpwm_cls_t   out_word
);
  import svpwm_pkg::*;

  // stage 1: squares, products and signs
  logic               s1_valid;
  logic signed [15:0] s1_ua, s1_ub;
  logic [15:0]        s1_udc;
  logic [33:0]        s1_a3sq;
  logic [31:0]        s1_bsq;
  logic signed [35:0] s1_sub;
  logic signed [35:0] s1_ua3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_ua   <= u_alpha;
      s1_ub   <= u_beta;
      s1_udc  <= bus_voltage;
      s1_a3sq <= 34'(3 * (32'($signed(u_alpha) * $signed(u_alpha))));
      s1_bsq  <= 32'($signed(u_beta) * $signed(u_beta));
      s1_sub  <= 36'($signed(u_beta) * $signed({1'b0, SQRT3_Q16}));
      s1_ua3  <= 36'($signed(u_alpha) * 36'sd196608);
    end
  end

  // sqrt(3)*a > b exact, given squares
  function automatic logic gt3(input logic signed [15:0] a, input logic signed [15:0] b,
                               input logic [33:0] a3, input logic [31:0] bs);
    logic r;
    if (a > 0) r = (b <= 0) || (a3 > {2'b0, bs});
    else if (a == 0) r = (b < 0);
    else r = (b < 0) && ({2'b0, bs} > a3);
    return r;
  endfunction

  logic [2:0]         sec;
  logic signed [36:0] x, y, z, va, vb;

  always_comb begin
    sec[0] = s1_ub > 0;
    sec[1] = gt3(s1_ua, s1_ub, s1_a3sq, s1_bsq);
    sec[2] = gt3(-17'(s1_ua) == 17'sd32768 ? 16'sh8000 : -s1_ua, s1_ub, s1_a3sq, s1_bsq);
    // -ua for -32768 overflows 16 bits; treat it by sign directly
    if (s1_ua == -16'sd32768) sec[2] = (s1_ub <= 0) || (s1_a3sq > {2'b0, s1_bsq});
    x = 37'(s1_sub) <<< 1;
    y = 37'(s1_ua3) - 37'(s1_sub);
    z = -37'(s1_ua3) - 37'(s1_sub);
    case (sec)
      3'd1: begin va = -y; vb = -z; end
      3'd2: begin va = -z; vb = -x; end
      3'd3: begin va = y;  vb = x;  end
      3'd4: begin va = -x; vb = -y; end
      3'd5: begin va = x;  vb = z;  end
      3'd6: begin va = z;  vb = y;  end
      default: begin va = '0; vb = '0; end
    endcase
  end

  // stage 2: classified word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
    if (adv) begin
      out_word.sector      <= (sec == 3'd7) ? 3'd0 : sec;
      out_word.act_a       <= (va > 0 && sec != 3'd7) ? va[35:0] : '0;
      out_word.act_b       <= (vb > 0 && sec != 3'd7) ? vb[35:0] : '0;
      out_word.bus_voltage <= s1_udc;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/svpwm_back.sv */
`default_nettype none
// ============================================================================
// svpwm_back
// Dwell-time division and compare assembly. Pipelined restoring divider,
// one quotient bit per stage, both times in parallel.
// ============================================================================
module svpwm_back #(
  parameter int TIME_FRAC_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  svpwm_pkg::svpwm_cls_t   in_word,
  input  wire [15:0]              period,
  input  wire                     adv,
  output logic                    out_valid,
  output logic [15:0]             compare_a,
  output logic [15:0]             compare_b,
  output logic [15:0]             compare_c,
  output logic [2:0]              sector,
  output logic                    overmodulated
);
  import svpwm_pkg::*;

  localparam int QW = 16 + TIME_FRAC_BITS + 1;  // quotient width (t <= per*2^F)
  localparam int NW = 52 + TIME_FRAC_BITS;      // numerator width
  localparam int DW = 37;                       // divisor width
  localparam int NS = QW;                       // divider stages
  localparam int TW = 18 + TIME_FRAC_BITS;

  // prep stage: product and divisor
  logic            p_valid;
  logic [NW-1:0]   p_na, p_nb;
  logic [DW-1:0]   p_d;
  logic [2:0]      p_sec;
  logic            p_over;
  logic [15:0]     p_per;
  logic [36:0]     vs, lim;

  assign vs  = {1'b0, in_word.act_a} + {1'b0, in_word.act_b};
  assign lim = {4'b0, in_word.bus_voltage, 17'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= in_valid;
    end
    if (adv) begin
      p_na   <= NW'({52'(in_word.act_a) * 52'(period), {TIME_FRAC_BITS{1'b0}}});
      p_nb   <= NW'({52'(in_word.act_b) * 52'(period), {TIME_FRAC_BITS{1'b0}}});
      p_over <= (vs != '0) && (vs > lim);
      p_d    <= (vs == '0) ? 37'd1 : ((vs > lim) ? vs : lim);
      p_sec  <= in_word.sector;
      p_per  <= period;
    end
  end

  // divider pipeline; stage k decides quotient bit NS-1-k
  logic                   d_valid [NS+1];
  logic [NW-1:0]          ra [NS+1];
  logic [NW-1:0]          rb [NS+1];
  logic [QW-1:0]          qa [NS+1];
  logic [QW-1:0]          qb [NS+1];
  logic [DW-1:0]          dd [NS+1];
  logic [2:0]             ds [NS+1];
  logic                   dov [NS+1];
  logic [15:0]            dp [NS+1];

  always_comb begin
    d_valid[0] = p_valid;
    ra[0] = p_na; rb[0] = p_nb; qa[0] = '0; qb[0] = '0;
    dd[0] = p_d; ds[0] = p_sec; dov[0] = p_over; dp[0] = p_per;
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int SH = NS - 1 - k;
    logic [NW+DW-1:0] sa, sb;
    logic             ga, gb;
    always_comb begin
      sa = (NW+DW)'(dd[k]) << SH;
      sb = sa;
      ga = (NW+DW)'(ra[k]) >= sa;
      gb = (NW+DW)'(rb[k]) >= sb;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k+1] <= 1'b0;
      end else if (adv) begin
        d_valid[k+1] <= d_valid[k];
      end
      if (adv) begin
        ra[k+1]  <= ga ? NW'((NW+DW)'(ra[k]) - sa) : ra[k];
        rb[k+1]  <= gb ? NW'((NW+DW)'(rb[k]) - sb) : rb[k];
        qa[k+1]  <= qa[k] | (QW'(ga) << SH);
        qb[k+1]  <= qb[k] | (QW'(gb) << SH);
        dd[k+1]  <= dd[k];
        ds[k+1]  <= ds[k];
        dov[k+1] <= dov[k];
        dp[k+1]  <= dp[k];
      end
    end
  end

  // compare assembly
  logic [TW-1:0] t1, t2, pq, t7, sfull, shalf;
  logic [15:0]   full, half, tz;

  function automatic logic [15:0] ticks(input logic [TW-1:0] v, input logic [15:0] p);
    logic [TW-1:0] t;
    t = v >> TIME_FRAC_BITS;
    return (t > TW'(p)) ? p : t[15:0];
  endfunction

  always_comb begin
    t1 = TW'(qa[NS]);
    t2 = TW'(qb[NS]);
    pq = TW'({dp[NS], {TIME_FRAC_BITS{1'b0}}});
    t7 = (t1 + t2 <= pq) ? (pq - t1 - t2) >> 1 : '0;
    sfull = t1 + t2 + t7;
    shalf = t2 + t7;
    full = ticks(sfull, dp[NS]);
    half = ticks(shalf, dp[NS]);
    tz   = ticks(t7, dp[NS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid[NS];
    end
    if (adv) begin
      sector        <= ds[NS];
      overmodulated <= dov[NS];
      case (ds[NS])
        3'd1: begin compare_a <= half; compare_b <= full; compare_c <= tz;   end
        3'd2: begin compare_a <= full; compare_b <= tz;   compare_c <= half; end
        3'd3: begin compare_a <= full; compare_b <= half; compare_c <= tz;   end
        3'd4: begin compare_a <= tz;   compare_b <= half; compare_c <= full; end
        3'd5: begin compare_a <= tz;   compare_b <= full; compare_c <= half; end
        3'd6: begin compare_a <= half; compare_b <= tz;   compare_c <= full; end
        default: begin compare_a <= tz; compare_b <= tz;  compare_c <= tz;   end
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/svpwm_skid.sv */
`default_nettype none
// ============================================================================
// svpwm_skid
// Two-entry output queue that decouples the pipeline from downstream stall.
// ============================================================================
module svpwm_skid (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire [50:0]  in_word,
  output logic        almost_full,
  output logic        out_valid,
  output logic [50:0] out_word,
  input  wire         out_stall
);
  logic [50:0] mem [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic        push, pop;

  assign out_valid   = cnt != 2'd0;
  assign out_word    = mem[rp];
  assign pop         = out_valid && !out_stall;
  assign push        = in_valid;
  // pipeline may advance while at least one entry is free
  assign almost_full = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= in_word;
  end
endmodule
`default_nettype wire

/* hw/rtl/svpwm_compare_generator.sv */
`default_nettype none
// ============================================================================
// svpwm_compare_generator
// Seven-segment space-vector PWM compare generator.
// ============================================================================
//  channel | signals                                   | flow
//  in      | in_valid/in_stall, u_alpha,u_beta,bus_vol  | one word per cycle unless stalled
//  out     | out_valid/out_stall, compare_a/b/c,sector  | one word per cycle unless stalled
//  cfg     | cfg_we, cfg_wdata (pwm_period)             | write only
// One word per cycle sustained while the output queue is not full; the
// stages are 2 front + 1 prep + (17+F) divider + 1 assembly, then the
// output queue. The pipeline advances as a whole; it holds only when the
// queue is full. Synchronous reset clears valid bits and sets the period to 1000.
module svpwm_compare_generator #(
  parameter int TIME_FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [15:0]        cfg_wdata,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] u_alpha,
  input  wire signed [15:0] u_beta,
  input  wire [15:0]        bus_voltage,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [15:0]       compare_a,
  output logic [15:0]       compare_b,
  output logic [15:0]       compare_c,
  output logic [2:0]        sector,
  output logic              overmodulated
);
  import svpwm_pkg::*;

  logic [15:0] period;
  always_ff @(posedge clk) begin
    if (rst) period <= PERIOD_RST;
    else if (cfg_we) period <= cfg_wdata;
  end

  logic       adv, full;
  logic       f_valid, b_valid;
  svpwm_cls_t f_word;
  logic [15:0] ca, cb, cc;
  logic [2:0]  sc;
  logic        ov;
  logic [50:0] q_out;

  assign adv      = !full;
  assign in_stall = full;

  svpwm_front u_front (
    .clk, .rst, .in_valid, .u_alpha, .u_beta, .bus_voltage, .adv,
    .out_valid(f_valid), .out_word(f_word)
  );

  svpwm_back #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(f_valid), .in_word(f_word), .period, .adv,
    .out_valid(b_valid), .compare_a(ca), .compare_b(cb), .compare_c(cc),
    .sector(sc), .overmodulated(ov)
  );

  svpwm_skid u_skid (
    .clk, .rst, .in_valid(b_valid && adv), .in_word({ca, cb, cc, sc}),
    .almost_full(full), .out_valid, .out_word(q_out), .out_stall
  );

  // overmodulated rides along as a separate flag queue bit
  logic [1:0] ovq;
  logic       ovw, ovr;
  always_ff @(posedge clk) begin
    if (rst) begin
      ovw <= 1'b0; ovr <= 1'b0;
    end else begin
      if (b_valid && adv) ovw <= ~ovw;
      if (out_valid && !out_stall) ovr <= ~ovr;
    end
    if (b_valid && adv) ovq[ovw] <= ov;
  end

  assign compare_a     = q_out[50:35];
  assign compare_b     = q_out[34:19];
  assign compare_c     = q_out[18:3];
  assign sector        = q_out[2:0];
  assign overmodulated = ovq[ovr];
endmodule
`default_nettype wire

/* hw/rtl/svpwm_checker.sv */
`default_nettype none
// ============================================================================
// svpwm_checker
// Port-level checks for the compare generator.
// ============================================================================
module svpwm_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] compare_a,
  input wire [15:0] compare_b,
  input wire [15:0] compare_c,
  input wire [2:0]  sector,
  input wire        overmodulated
);
  // sector code seven never appears
  assert property (@(posedge clk) disable iff (rst) out_valid |-> sector != 3'd7)
    else $error("bad sector");
  // zero vector is never overmodulated and gives equal compares
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && sector == 3'd0) |-> (!overmodulated && compare_a == compare_b
                                       && compare_b == compare_c))
    else $error("zero vector compares");
  // stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(compare_a) && $stable(sector)))
    else $error("stalled word changed");
  // nothing comes out right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind svpwm_compare_generator svpwm_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .compare_a, .compare_b, .compare_c,
  .sector, .overmodulated
);
`default_nettype wire

/* tb/sv/svpwm_compare_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svpwm_compare_checker
// Watches the vector and compare channels of the SVPWM compare generator,
// predicts the compare word for every accepted vector word and compares
// field by field in order.
// ----------------------------------------------------------------------------
module svpwm_compare_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [15:0]        cfg_wdata,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire signed [15:0] u_alpha,
  input  wire signed [15:0] u_beta,
  input  wire [15:0]        bus_voltage,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire [15:0]        compare_a,
  input  wire [15:0]        compare_b,
  input  wire [15:0]        compare_c,
  input  wire [2:0]         sector,
  input  wire               overmodulated,
  output int                fail_count,
  output int                pending
);

  localparam int FRAC = 16;
  localparam longint ROOT3_Q16 = 113512;

  typedef struct packed {
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
    logic [2:0]  sec;
    logic        ovm;
  } compare_word_t;

  compare_word_t compare_q[$];
  logic [15:0]   period_reg;
  int            mismatch_count;

  assign pending = compare_q.size();

  // exact test of sqrt(3)*a > b
  function automatic bit root3_above(longint a, longint b);
    if (a > 0) return (b <= 0) ? 1'b1 : (3 * a * a > b * b);
    if (a == 0) return b < 0;
    if (b >= 0) return 1'b0;
    return b * b > 3 * a * a;
  endfunction

  // floor(n * 2^F / d)
  function automatic longint unsigned scaled_div(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    return (q << FRAC) + ((r << FRAC) / d);
  endfunction

  function automatic longint unsigned ticks(longint unsigned v, longint unsigned per);
    longint unsigned t;
    t = v >> FRAC;
    return (t > per) ? per : t;
  endfunction

  function automatic compare_word_t predict_compares(logic signed [15:0] ua16,
      logic signed [15:0] ub16, logic [15:0] udc16, logic [15:0] per16);
    compare_word_t w;
    longint ua, ub, x, y, z, va, vb;
    longint unsigned a, b, vs, lim, t1, t2, t7, pq, full, half, per;
    logic [15:0] f16, h16, z16;
    logic [2:0] sec;
    bit over;
    ua = longint'(ua16); ub = longint'(ub16); per = longint'(per16);
    sec = 3'd0; va = 0; vb = 0; t1 = 0; t2 = 0; over = 1'b0;
    if (ub > 0) sec[0] = 1'b1;
    if (root3_above(ua, ub)) sec[1] = 1'b1;
    if (root3_above(-ua, ub)) sec[2] = 1'b1;
    x = 2 * ROOT3_Q16 * ub;
    y = 3 * 65536 * ua - ROOT3_Q16 * ub;
    z = -3 * 65536 * ua - ROOT3_Q16 * ub;
    case (sec)
      3'd1: begin va = -y; vb = -z; end
      3'd2: begin va = -z; vb = -x; end
      3'd3: begin va = y;  vb = x;  end
      3'd4: begin va = -x; vb = -y; end
      3'd5: begin va = x;  vb = z;  end
      3'd6: begin va = z;  vb = y;  end
      default: sec = 3'd0;
    endcase
    a = (va > 0) ? va : 0;
    b = (vb > 0) ? vb : 0;
    vs = a + b;
    if (vs != 0) begin
      lim = longint'(udc16) << 17;
      if (vs > lim) begin
        over = 1'b1;
        t1 = scaled_div(a * per, vs);
        t2 = scaled_div(b * per, vs);
      end else begin
        t1 = scaled_div(a * per, lim);
        t2 = scaled_div(b * per, lim);
      end
    end
    pq = per << FRAC;
    t7 = (t1 + t2 <= pq) ? (pq - t1 - t2) >> 1 : 0;
    full = ticks(t1 + t2 + t7, per);
    half = ticks(t2 + t7, per);
    t7 = ticks(t7, per);
    f16 = 16'(full);
    h16 = 16'(half);
    z16 = 16'(t7);
    case (sec)
      3'd1: begin w.ca = h16; w.cb = f16; w.cc = z16; end
      3'd2: begin w.ca = f16; w.cb = z16; w.cc = h16; end
      3'd3: begin w.ca = f16; w.cb = h16; w.cc = z16; end
      3'd4: begin w.ca = z16; w.cb = h16; w.cc = f16; end
      3'd5: begin w.ca = z16; w.cb = f16; w.cc = h16; end
      3'd6: begin w.ca = h16; w.cb = z16; w.cc = f16; end
      default: begin w.ca = z16; w.cb = z16; w.cc = z16; end
    endcase
    w.sec = sec;
    w.ovm = over;
    return w;
  endfunction

  // track period, queue predictions, check compare words
  always @(posedge clk) begin
    compare_word_t exp_w, got_w;
    if (rst) begin
      period_reg <= 16'd1000;
      compare_q.delete();
      fail_count <= 0;
      mismatch_count = 0;
    end else begin
      if (cfg_we) period_reg <= cfg_wdata;
      if (in_valid && !in_stall)
        compare_q.push_back(predict_compares(u_alpha, u_beta, bus_voltage, period_reg));
      if (out_valid && !out_stall) begin
        got_w = '{compare_a, compare_b, compare_c, sector, overmodulated};
        if (compare_q.size() == 0) begin
          fail_count <= fail_count + 1;
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected compare word %h", got_w);
        end else begin
          exp_w = compare_q.pop_front();
          if (exp_w !== got_w) begin
            fail_count <= fail_count + 1;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: exp a=%0d b=%0d c=%0d sec=%0d ovm=%0d,",
                        " got a=%0d b=%0d c=%0d sec=%0d ovm=%0d"},
                exp_w.ca, exp_w.cb, exp_w.cc, exp_w.sec, exp_w.ovm,
                got_w.ca, got_w.cb, got_w.cc, got_w.sec, got_w.ovm);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/svpwm_compare_generator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svpwm_compare_generator_test
// Drives directed and random alpha/beta vectors through the compare
// generator over several PWM periods with random bursts and output stalls;
// the checker predicts and compares every compare word.
// ----------------------------------------------------------------------------
module svpwm_compare_generator_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk, rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid, in_stall;
  logic signed [15:0] u_alpha, u_beta;
  logic [15:0] bus_voltage;
  logic        out_valid, out_stall;
  logic [15:0] compare_a, compare_b, compare_c;
  logic [2:0]  sector;
  logic        overmodulated;
  int          fail_count, pending;
  int          idle_cycles;
  bit          hold_off, stim_done;

  svpwm_compare_generator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .u_alpha(u_alpha), .u_beta(u_beta),
    .bus_voltage(bus_voltage), .out_valid(out_valid), .out_stall(out_stall),
    .compare_a(compare_a), .compare_b(compare_b), .compare_c(compare_c),
    .sector(sector), .overmodulated(overmodulated)
  );

  svpwm_compare_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .u_alpha(u_alpha), .u_beta(u_beta),
    .bus_voltage(bus_voltage), .out_valid(out_valid), .out_stall(out_stall),
    .compare_a(compare_a), .compare_b(compare_b), .compare_c(compare_c),
    .sector(sector), .overmodulated(overmodulated),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall pattern; a long hold-off when requested
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= ($urandom_range(0, 2) != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || stim_done && pending == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** svpwm_compare_generator: FAILED **");
      $finish;
    end
  end

  // offer one vector word and wait for acceptance
  task automatic send_vector(logic [15:0] ua, logic [15:0] ub, logic [15:0] udc);
    in_valid    <= 1'b1;
    u_alpha     <= ua;
    u_beta      <= ub;
    bus_voltage <= udc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] per);
    in_valid  <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly in-range vectors, some full-scale noise and some tiny terms
  task automatic random_vector();
    logic [15:0] ua, ub, udc;
    int mode;
    mode = $urandom_range(0, 9);
    udc = 16'($urandom_range(1, 65535));
    if (mode < 6) begin
      udc = 16'($urandom_range(1000, 65535));
      ua = $signed(16'($urandom_range(0, udc))) >>> 1;
      ub = $signed(16'($urandom_range(0, udc))) >>> 1;
      if ($urandom_range(0, 1)) ua = -ua;
      if ($urandom_range(0, 1)) ub = -ub;
    end else if (mode < 8) begin
      ua = 16'($urandom);
      ub = 16'($urandom);
    end else begin
      ua = 16'($urandom_range(0, 7)) - 16'd3;
      ub = 16'($urandom_range(0, 7)) - 16'd3;
      udc = $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(1, 65535));
    end
    send_vector(ua, ub, udc);
  endtask

  task automatic random_phase(int count);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && sent < count) begin
        random_vector();
        sent++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [15:0] periods[5];
    int p;
    periods = '{16'd65535, 16'd1, 16'd0, 16'd4096, 16'd1000};
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0;
    u_alpha = '0; u_beta = '0; bus_voltage = 16'd1; hold_off = 1'b0; stim_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, extremes, each sector, bus zero, tiny terms
    send_vector(16'sd0, 16'sd0, 16'd100);
    send_vector(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    send_vector(16'sh8000, 16'sh8000, 16'hFFFF);
    send_vector(16'sh7FFF, 16'sh8000, 16'd1);
    send_vector(16'sh8000, 16'sh7FFF, 16'd1);
    send_vector(16'sd1000, 16'sd300, 16'd4000);
    send_vector(16'sd0, 16'sd1000, 16'd4000);
    send_vector(-16'sd1000, 16'sd300, 16'd4000);
    send_vector(-16'sd1000, -16'sd300, 16'd4000);
    send_vector(16'sd0, -16'sd1000, 16'd4000);
    send_vector(16'sd1000, -16'sd300, 16'd4000);
    send_vector(16'sd1000, 16'sd0, 16'd0);
    send_vector(16'sd0, 16'sd0, 16'd0);
    send_vector(16'sd1, 16'sd1, 16'd0);
    send_vector(16'sd4, 16'sd7, 16'd3);
    send_vector(16'sd7, -16'sd4, 16'hFFFF);
    send_vector(16'sd20000, 16'sd20000, 16'd100);
    random_phase(300);

    // long output hold-off while vectors keep coming
    hold_off = 1'b1;
    random_phase(120);
    hold_off = 1'b0;

    for (p = 0; p < 5; p++) begin
      write_period(periods[p]);
      random_phase(250);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** svpwm_compare_generator: PASSED **");
    else
      $display("** svpwm_compare_generator: FAILED **");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_front.sv
hw/rtl/svpwm_back.sv
hw/rtl/svpwm_skid.sv
hw/rtl/svpwm_compare_generator.sv
hw/rtl/svpwm_checker.sv
tb/sv/svpwm_compare_checker.sv
tb/sv/svpwm_compare_generator_test.sv
